// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, beat layouts, stage payloads and helpers for the triangle
// pixel coverage pipeline.
// ----------------------------------------------------------------------------
package tpc_pkg;

	// fixed point formats
	localparam int COORD_FRAC_BITS  = 4;
	localparam int WEIGHT_FRAC_BITS = 16;

	// field widths
	localparam int COORD_W  = 16;
	localparam int PIXEL_W  = 10;
	localparam int SIZE_W   = 11;
	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

	// datapath widths
	localparam int PIX_FX_W = PIXEL_W + COORD_FRAC_BITS;
	localparam int DIFF_W   = ((COORD_W > PIX_FX_W + 1) ? COORD_W : PIX_FX_W + 1) + 1;
	localparam int BOX_W    = DIFF_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int EDGE_W   = PROD_W + 1;
	localparam int SUM_W    = EDGE_W + 2;
	localparam int MAG_W    = EDGE_W;

	// one quotient bit per divider stage
	localparam int DIV_STAGES = WEIGHT_W;
	localparam int LANES      = 3;

	// |area| at or below this is a degenerate triangle
	localparam int DEGEN_LIMIT = (1 << (2 * COORD_FRAC_BITS)) / 100;

	// beat layouts
	localparam int IN_BITS   = 6 * COORD_W + 2 * PIXEL_W;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + 3 * WEIGHT_W;
	localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// configuration port
	localparam int                CFG_ADDR_W = 1;
	localparam logic [SIZE_W-1:0] IMG_SIZE_RESET = SIZE_W'(200);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	// input beat, first field in the low bits
	typedef struct packed {
		logic        [PIXEL_W-1:0] pixel_y;
		logic        [PIXEL_W-1:0] pixel_x;
		logic signed [COORD_W-1:0] vertex_c_y;
		logic signed [COORD_W-1:0] vertex_c_x;
		logic signed [COORD_W-1:0] vertex_b_y;
		logic signed [COORD_W-1:0] vertex_b_x;
		logic signed [COORD_W-1:0] vertex_a_y;
		logic signed [COORD_W-1:0] vertex_a_x;
	} tpc_in_t;

	// result beat, first field in the low bits
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight_c;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_a;
		logic                covered;
	} tpc_result_t;

	// front stage -> edge pipeline
	typedef struct packed {
		logic signed [DIFF_W-1:0] dbx;   // bx - ax
		logic signed [DIFF_W-1:0] dby;   // by - ay
		logic signed [DIFF_W-1:0] dcx;   // cx - ax
		logic signed [DIFF_W-1:0] dcy;   // cy - ay
		logic signed [DIFF_W-1:0] dpx;   // ax - px
		logic signed [DIFF_W-1:0] dpy;   // ay - py
		logic                     in_box;
	} tpc_diff_t;

	// edge pipeline -> divider; num[0..2] are the numerators of weights a, b, c
	typedef struct packed {
		logic                        covered;
		logic [MAG_W-1:0]            den;
		logic [LANES-1:0][MAG_W-1:0] num;
	} tpc_div_in_t;

	typedef struct packed {
		logic             q_bit;
		logic [MAG_W-1:0] rem;
	} div_step_t;

	// sample inside the vertex box clipped to [0, lim]
	function automatic logic box_hit(
		input logic signed [COORD_W-1:0]  a,
		input logic signed [COORD_W-1:0]  b,
		input logic signed [COORD_W-1:0]  c,
		input logic        [PIX_FX_W-1:0] p,
		input logic signed [BOX_W-1:0]    lim
	);
		logic signed [BOX_W-1:0] ea, eb, ec, ep, lo, hi;
		ea = BOX_W'(a);
		eb = BOX_W'(b);
		ec = BOX_W'(c);
		ep = BOX_W'(signed'({1'b0, p}));
		lo = lim;
		if (ea < lo) lo = ea;
		if (eb < lo) lo = eb;
		if (ec < lo) lo = ec;
		if (lo[BOX_W-1]) lo = '0;
		hi = '0;
		if (ea > hi) hi = ea;
		if (eb > hi) hi = eb;
		if (ec > hi) hi = ec;
		if (hi > lim) hi = lim;
		return (ep >= lo) && (ep <= hi);
	endfunction

	// one restoring division step
	function automatic div_step_t div_step(
		input logic [MAG_W:0]   trial,
		input logic [MAG_W-1:0] den
	);
		div_step_t        r;
		logic [MAG_W:0]   diff;
		diff    = trial - {1'b0, den};
		r.q_bit = (trial >= {1'b0, den});
		r.rem   = r.q_bit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front
// Stage 1: vertex/sample differences and clipped bounding box test.
// ----------------------------------------------------------------------------
module tpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              in_vld,
	input  tpc_pkg::tpc_in_t                  in_item,
	input  logic [tpc_pkg::SIZE_W-1:0]        image_width,
	input  logic [tpc_pkg::SIZE_W-1:0]        image_height,
	output logic                              out_vld,
	output tpc_pkg::tpc_diff_t                out_diff
);

	logic [tpc_pkg::PIX_FX_W-1:0]      px_fx, py_fx;
	logic signed [tpc_pkg::BOX_W-1:0]  lim_x, lim_y;
	logic signed [tpc_pkg::DIFF_W-1:0] ax, ay;
	tpc_pkg::tpc_diff_t                diff;
	logic                              vld_s1;
	tpc_pkg::tpc_diff_t                diff_s1;

	always_comb begin
		px_fx = tpc_pkg::PIX_FX_W'(in_item.pixel_x) << tpc_pkg::COORD_FRAC_BITS;
		py_fx = tpc_pkg::PIX_FX_W'(in_item.pixel_y) << tpc_pkg::COORD_FRAC_BITS;
		// (size - 1) in 12.4; negative for a zero size, which empties the box
		lim_x = (tpc_pkg::BOX_W'(signed'({1'b0, image_width})) - tpc_pkg::BOX_W'(1))
			<<< tpc_pkg::COORD_FRAC_BITS;
		lim_y = (tpc_pkg::BOX_W'(signed'({1'b0, image_height})) - tpc_pkg::BOX_W'(1))
			<<< tpc_pkg::COORD_FRAC_BITS;
		ax = tpc_pkg::DIFF_W'(in_item.vertex_a_x);
		ay = tpc_pkg::DIFF_W'(in_item.vertex_a_y);
		diff.dbx = tpc_pkg::DIFF_W'(in_item.vertex_b_x) - ax;
		diff.dby = tpc_pkg::DIFF_W'(in_item.vertex_b_y) - ay;
		diff.dcx = tpc_pkg::DIFF_W'(in_item.vertex_c_x) - ax;
		diff.dcy = tpc_pkg::DIFF_W'(in_item.vertex_c_y) - ay;
		diff.dpx = ax - tpc_pkg::DIFF_W'(signed'({1'b0, px_fx}));
		diff.dpy = ay - tpc_pkg::DIFF_W'(signed'({1'b0, py_fx}));
		diff.in_box =
			tpc_pkg::box_hit(in_item.vertex_a_x, in_item.vertex_b_x, in_item.vertex_c_x,
				px_fx, lim_x) &&
			tpc_pkg::box_hit(in_item.vertex_a_y, in_item.vertex_b_y, in_item.vertex_c_y,
				py_fx, lim_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s1 <= diff;
		end
	end

	assign out_vld  = vld_s1;
	assign out_diff = diff_s1;

endmodule

// ===== rtl/tpc_edge.sv =====
// ----------------------------------------------------------------------------
// tpc_edge
// Stages 2-5: edge products, edge terms, degeneracy and side tests, and the
// sign-folded magnitudes handed to the divider.
// ----------------------------------------------------------------------------
module tpc_edge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_vld,
	input  tpc_pkg::tpc_diff_t   in_diff,
	output logic                 out_vld,
	output tpc_pkg::tpc_div_in_t out_div
);

	// s2: products
	logic                              vld_s2, in_box_s2;
	logic signed [tpc_pkg::PROD_W-1:0] ux0_s2, ux1_s2, uy0_s2, uy1_s2, uz0_s2, uz1_s2;
	// s3: edge terms
	logic                              vld_s3, in_box_s3;
	logic signed [tpc_pkg::EDGE_W-1:0] ux_s3, uy_s3, uz_s3;
	// s4: weight-a numerator, degeneracy
	logic                              vld_s4, ok_s4;
	logic signed [tpc_pkg::EDGE_W-1:0] ux_s4, uy_s4, uz_s4;
	logic signed [tpc_pkg::SUM_W-1:0]  na_s4;
	// s5: folded magnitudes
	logic                              vld_s5;
	tpc_pkg::tpc_div_in_t              div_s5;

	logic signed [tpc_pkg::SUM_W-1:0]  na;
	logic                              degen;
	logic                              neg, side_ok;
	tpc_pkg::tpc_div_in_t              div_nxt;

	always_comb begin
		na = tpc_pkg::SUM_W'(uz_s3) - tpc_pkg::SUM_W'(ux_s3) - tpc_pkg::SUM_W'(uy_s3);
		degen = (uz_s3 <= tpc_pkg::EDGE_W'(tpc_pkg::DEGEN_LIMIT)) &&
			(uz_s3 >= -tpc_pkg::EDGE_W'(tpc_pkg::DEGEN_LIMIT));
	end

	always_comb begin
		neg = uz_s4[tpc_pkg::EDGE_W-1];
		// edge samples (zero numerator) count as inside
		if (neg) begin
			side_ok = (na_s4 <= 0) && (ux_s4 <= 0) && (uy_s4 <= 0);
		end else begin
			side_ok = (na_s4 >= 0) && (ux_s4 >= 0) && (uy_s4 >= 0);
		end
		div_nxt.covered = ok_s4 && side_ok;
		div_nxt.den     = tpc_pkg::MAG_W'(neg ? -uz_s4 : uz_s4);
		div_nxt.num[0]  = tpc_pkg::MAG_W'(neg ? -na_s4 : na_s4);
		div_nxt.num[1]  = tpc_pkg::MAG_W'(neg ? -uy_s4 : uy_s4);
		div_nxt.num[2]  = tpc_pkg::MAG_W'(neg ? -ux_s4 : ux_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_box_s2 <= in_diff.in_box;
			ux0_s2    <= in_diff.dbx * in_diff.dpy;
			ux1_s2    <= in_diff.dpx * in_diff.dby;
			uy0_s2    <= in_diff.dpx * in_diff.dcy;
			uy1_s2    <= in_diff.dcx * in_diff.dpy;
			uz0_s2    <= in_diff.dcx * in_diff.dby;
			uz1_s2    <= in_diff.dbx * in_diff.dcy;

			in_box_s3 <= in_box_s2;
			ux_s3     <= tpc_pkg::EDGE_W'(ux0_s2) - tpc_pkg::EDGE_W'(ux1_s2);
			uy_s3     <= tpc_pkg::EDGE_W'(uy0_s2) - tpc_pkg::EDGE_W'(uy1_s2);
			uz_s3     <= tpc_pkg::EDGE_W'(uz0_s2) - tpc_pkg::EDGE_W'(uz1_s2);

			ok_s4     <= in_box_s3 && !degen;
			ux_s4     <= ux_s3;
			uy_s4     <= uy_s3;
			uz_s4     <= uz_s3;
			na_s4     <= na;

			div_s5    <= div_nxt;
		end
	end

	assign out_vld = vld_s5;
	assign out_div = div_s5;

endmodule

// ===== rtl/tpc_divider.sv =====
// ----------------------------------------------------------------------------
// tpc_divider
// Three-lane pipelined restoring divider, one quotient bit per stage,
// integer bit first. Uncovered items leave with zero weights.
// ----------------------------------------------------------------------------
module tpc_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_vld,
	input  tpc_pkg::tpc_div_in_t in_div,
	output logic                 out_vld,
	output tpc_pkg::tpc_result_t out_res
);

	localparam int LAST = tpc_pkg::DIV_STAGES - 1;

	logic [tpc_pkg::MAG_W-1:0]    rem_s [tpc_pkg::DIV_STAGES][tpc_pkg::LANES];
	logic [tpc_pkg::WEIGHT_W-1:0] quo_s [tpc_pkg::DIV_STAGES][tpc_pkg::LANES];
	logic [tpc_pkg::MAG_W-1:0]    den_s [tpc_pkg::DIV_STAGES];
	logic                         cov_s [tpc_pkg::DIV_STAGES];
	logic                         vld_s [tpc_pkg::DIV_STAGES];

	for (genvar k = 0; k < tpc_pkg::DIV_STAGES; k++) begin : g_step
		logic [tpc_pkg::MAG_W:0]      trial  [tpc_pkg::LANES];
		logic [tpc_pkg::WEIGHT_W-1:0] quo_in [tpc_pkg::LANES];
		tpc_pkg::div_step_t           step   [tpc_pkg::LANES];
		logic [tpc_pkg::MAG_W-1:0]    den_in;
		logic                         cov_in, vld_in;

		if (k == 0) begin : g_first
			// numerator never exceeds the denominator when covered: no shift
			always_comb begin
				den_in = in_div.den;
				cov_in = in_div.covered;
				vld_in = in_vld;
				for (int l = 0; l < tpc_pkg::LANES; l++) begin
					trial[l]  = {1'b0, in_div.num[l]};
					quo_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				den_in = den_s[k-1];
				cov_in = cov_s[k-1];
				vld_in = vld_s[k-1];
				for (int l = 0; l < tpc_pkg::LANES; l++) begin
					trial[l]  = {rem_s[k-1][l], 1'b0};
					quo_in[l] = quo_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < tpc_pkg::LANES; l++) begin
				step[l] = tpc_pkg::div_step(trial[l], den_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (advance) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				den_s[k] <= den_in;
				cov_s[k] <= cov_in;
				for (int l = 0; l < tpc_pkg::LANES; l++) begin
					rem_s[k][l] <= step[l].rem;
					quo_s[k][l] <= {quo_in[l][tpc_pkg::WEIGHT_W-2:0], step[l].q_bit};
				end
			end
		end
	end

	// covered numerators are at most the denominator, so quotients stay <= 1.0
	always_comb begin
		out_vld          = vld_s[LAST];
		out_res.covered  = cov_s[LAST];
		out_res.weight_a = cov_s[LAST] ? quo_s[LAST][0] : '0;
		out_res.weight_b = cov_s[LAST] ? quo_s[LAST][1] : '0;
		out_res.weight_c = cov_s[LAST] ? quo_s[LAST][2] : '0;
	end

endmodule

// ===== rtl/tpc_out_buf.sv =====
// ----------------------------------------------------------------------------
// tpc_out_buf
// Output register plus skid entry; the skid state alone sets the pipeline
// advance, so no ready path runs combinationally from output to input.
// ----------------------------------------------------------------------------
module tpc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  tpc_pkg::tpc_result_t in_res,
	output logic                 ready,
	output logic                 out_vld,
	input  logic                 out_tready,
	output tpc_pkg::tpc_result_t out_res
);

	logic                 out_vld_q, skid_vld_q;
	tpc_pkg::tpc_result_t out_res_q, skid_res_q;
	logic                 out_free;

	assign out_free = !out_vld_q || out_tready;
	assign ready    = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// skid drains first; pipeline is stalled while it is full
			out_vld_q  <= skid_vld_q || in_vld;
			skid_vld_q <= 1'b0;
		end else if (in_vld && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_vld_q ? skid_res_q : in_res;
		end else if (!skid_vld_q) begin
			skid_res_q <= in_res;
		end
	end

	assign out_vld = out_vld_q;
	assign out_res = out_res_q;

endmodule

// ===== rtl/triangle_pixel_coverage.sv =====
// ----------------------------------------------------------------------------
// triangle_pixel_coverage
// Barycentric coverage test of one integer pixel sample against a 12.4
// triangle, with degenerate and clipped bounding-box rejection; returns
// coverage and three 1.16 barycentric weights per beat.
// ----------------------------------------------------------------------------
//
// channel  dir  width        contents
// -------  ---  -----------  ------------------------------------------------
// cfg      in   we/1/11      reg 0 image_width, reg 1 image_height
// s_axis   in   120 tdata    a_x a_y b_x b_y c_x c_y (s16 each), pixel_x/y (u10)
// m_axis   out  56 tdata     covered, weight_a, weight_b, weight_c (u17 each)
//
// One beat per cycle while not stalled; stages in order: front (1), products,
// edge terms, area check, sign fold (4), divider (17, one quotient bit per
// stage in each of three lanes), output register (1).
// arst_n clears all valid bits and sets both image sizes to 200.
// Any stall stops the whole pipeline in place; s_tready falls only while the
// skid entry behind the output register is occupied.
// Config is sampled at the front stage; write it only with the pipe empty.
//
module triangle_pixel_coverage (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_wr_en,
	input  logic [tpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tpc_pkg::SIZE_W-1:0]         cfg_wr_data,
	// sample stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
	// pixel_x, pixel_y, 4 zero pad bits
	input  logic [tpc_pkg::S_TDATA_W-1:0]      s_tdata,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// covered, weight_a, weight_b, weight_c, 4 zero pad bits
	output logic [tpc_pkg::M_TDATA_W-1:0]      m_tdata
);

	logic [tpc_pkg::SIZE_W-1:0] image_width_q, image_height_q;

	logic                       advance;
	tpc_pkg::tpc_in_t           in_item;
	logic                       front_vld;
	tpc_pkg::tpc_diff_t         front_diff;
	logic                       edge_vld;
	tpc_pkg::tpc_div_in_t       edge_div;
	logic                       div_vld;
	tpc_pkg::tpc_result_t       div_res;
	tpc_pkg::tpc_result_t       m_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= tpc_pkg::IMG_SIZE_RESET;
			image_height_q <= tpc_pkg::IMG_SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (tpc_pkg::reg_index_t'(cfg_addr))
				tpc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wr_data;
				tpc_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wr_data;
			endcase
		end
	end

	// whole pipe moves together; held only while the skid entry is full
	assign s_tready = advance;
	assign in_item  = tpc_pkg::tpc_in_t'(s_tdata[tpc_pkg::IN_BITS-1:0]);

	tpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_vld       (s_tvalid),
		.in_item      (in_item),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.out_vld      (front_vld),
		.out_diff     (front_diff)
	);

	tpc_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_vld  (front_vld),
		.in_diff (front_diff),
		.out_vld (edge_vld),
		.out_div (edge_div)
	);

	tpc_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_vld  (edge_vld),
		.in_div  (edge_div),
		.out_vld (div_vld),
		.out_res (div_res)
	);

	tpc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (div_vld),
		.in_res     (div_res),
		.ready      (advance),
		.out_vld    (m_tvalid),
		.out_tready (m_tready),
		.out_res    (m_res)
	);

	assign m_tdata = tpc_pkg::M_TDATA_W'(m_res);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	localparam int SUM_CHK_W = tpc_pkg::WEIGHT_W + 2;
	localparam logic [SUM_CHK_W-1:0] WEIGHT_ONE =
		SUM_CHK_W'(1) << tpc_pkg::WEIGHT_FRAC_BITS;

	logic [SUM_CHK_W-1:0] weight_sum;
	assign weight_sum = SUM_CHK_W'(m_res.weight_a) + SUM_CHK_W'(m_res.weight_b) +
		SUM_CHK_W'(m_res.weight_c);

	// input backs up only while a result sits unaccepted
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// skid fills only after the output was held
	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("skid entry filled without output back-pressure");

	// uncovered results carry zero weights
	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_res.covered |->
			(m_res.weight_a == '0) && (m_res.weight_b == '0) && (m_res.weight_c == '0))
		else $error("nonzero weight on uncovered sample");

	// floored weights of a covered sample sum to one, less at most two lsb
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_res.covered |->
			(weight_sum <= WEIGHT_ONE) && (weight_sum + SUM_CHK_W'(2) >= WEIGHT_ONE))
		else $error("barycentric weights do not sum to one");

endmodule

// ===== tb/coverage_checker.sv =====
// ----------------------------------------------------------------------------
// coverage_checker
// Watches the config port and both streams of triangle_pixel_coverage. It
// predicts each result from the accepted sample beat and the tracked image
// size, then compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module coverage_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tpc_pkg::SIZE_W-1:0]     cfg_wr_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tpc_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tpc_pkg::M_TDATA_W-1:0]  m_tdata,
	output int                             fail_count,
	output int                             outstanding
);
	import tpc_pkg::*;

	logic [SIZE_W-1:0] width_px;
	logic [SIZE_W-1:0] height_px;
	tpc_result_t       pending_results[$];
	int                errors;

	// box of three vertices clipped to [0, (size-1) in 12.4], one axis
	function automatic logic sample_in_box(input longint a, input longint b,
			input longint c, input longint p, input longint size);
		longint lim, lo, hi;
		longint v[3];
		lim = (size - 1) * (longint'(1) << COORD_FRAC_BITS);
		lo  = lim;
		hi  = 0;
		v   = '{a, b, c};
		for (int i = 0; i < 3; i++) begin
			lo = (v[i] < lo) ? v[i] : lo;
			lo = (lo < 0) ? 0 : lo;
			hi = (v[i] > hi) ? v[i] : hi;
			hi = (hi > lim) ? lim : hi;
		end
		return (p >= lo) && (p <= hi);
	endfunction

	// floor(num / den) in 1.16, clamped to one
	function automatic logic [WEIGHT_W-1:0] weight_of(input longint num, input longint den);
		longint q;
		q = (num << WEIGHT_FRAC_BITS) / den;
		if (q > (longint'(1) << WEIGHT_FRAC_BITS))
			q = longint'(1) << WEIGHT_FRAC_BITS;
		return WEIGHT_W'(q);
	endfunction

	function automatic tpc_result_t predict_coverage(input tpc_in_t s,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		tpc_result_t r;
		longint ax, ay, bx, by, cx, cy, px, py;
		longint ux, uy, uz, na;
		r  = '0;
		ax = longint'($signed(s.vertex_a_x));
		ay = longint'($signed(s.vertex_a_y));
		bx = longint'($signed(s.vertex_b_x));
		by = longint'($signed(s.vertex_b_y));
		cx = longint'($signed(s.vertex_c_x));
		cy = longint'($signed(s.vertex_c_y));
		px = longint'(s.pixel_x) << COORD_FRAC_BITS;
		py = longint'(s.pixel_y) << COORD_FRAC_BITS;
		if (!sample_in_box(ax, bx, cx, px, longint'(w)) ||
				!sample_in_box(ay, by, cy, py, longint'(h)))
			return r;
		ux = (bx - ax) * (ay - py) - (ax - px) * (by - ay);
		uy = (ax - px) * (cy - ay) - (cx - ax) * (ay - py);
		uz = (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
		// near-zero area: degenerate triangle
		if (((uz < 0) ? -uz : uz) <= DEGEN_LIMIT)
			return r;
		na = uz - ux - uy;
		// fold winding so the area is positive
		if (uz < 0) begin
			uz = -uz;
			ux = -ux;
			uy = -uy;
			na = -na;
		end
		if (na < 0 || uy < 0 || ux < 0)
			return r;
		r.covered  = 1'b1;
		r.weight_a = weight_of(na, uz);
		r.weight_b = weight_of(uy, uz);
		r.weight_c = weight_of(ux, uz);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tpc_result_t got;
		tpc_result_t want;
		if (!arst_n) begin
			width_px  = IMG_SIZE_RESET;
			height_px = IMG_SIZE_RESET;
			pending_results.delete();
			errors = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// sample beats use the size held before any write on this edge
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_coverage(
					tpc_in_t'(s_tdata[IN_BITS-1:0]), width_px, height_px));
			if (m_tvalid && m_tready) begin
				got = tpc_result_t'(m_tdata[OUT_BITS-1:0]);
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with none expected, expected none, %s",
						$time, "actual");
					$display("%0t: actual %0d %0d %0d %0d", $time,
						got.covered, got.weight_a, got.weight_b, got.weight_c);
				end else begin
					want = pending_results.pop_front();
					check_field("covered", want.covered, got.covered);
					check_field("weight_a", want.weight_a, got.weight_a);
					check_field("weight_b", want.weight_b, got.weight_b);
					check_field("weight_c", want.weight_c, got.weight_c);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH: begin
						width_px = cfg_wr_data;
					end
					REG_IMAGE_HEIGHT: begin
						height_px = cfg_wr_data;
					end
					default: ;
				endcase
			end
			fail_count  <= errors;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for triangle_pixel_coverage: directed triangles, then
// random phases over several image sizes and idle/stall mixes; checking is
// left to coverage_checker.
// ----------------------------------------------------------------------------
module tb;
	import tpc_pkg::*;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
	logic [SIZE_W-1:0]     cfg_wr_data = '0;
	logic                  s_tvalid    = 1'b0;
	logic                  s_tready;
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
	// pixel_x, pixel_y, zero pad
	logic [S_TDATA_W-1:0]  s_tdata     = '0;
	logic                  m_tvalid;
	logic                  m_tready    = 1'b0;
	// covered, weight_a, weight_b, weight_c, zero pad
	logic [M_TDATA_W-1:0]  m_tdata;

	int fail_count;
	int outstanding;

	// percent of cycles the sender holds off / the receiver stalls
	int send_idle_pct = 0;
	int stall_pct     = 0;

	always #5 clk = ~clk;

	triangle_pixel_coverage uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	coverage_checker cov_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic longint clamp_coord(input longint v);
		if (v < -32768)
			return -32768;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	// coordinates in raw 12.4 units, pixel in whole pixels
	function automatic tpc_in_t triangle_item(input int ax, input int ay, input int bx,
			input int by, input int cx, input int cy, input int px, input int py);
		tpc_in_t s;
		s.vertex_a_x = COORD_W'(ax);
		s.vertex_a_y = COORD_W'(ay);
		s.vertex_b_x = COORD_W'(bx);
		s.vertex_b_y = COORD_W'(by);
		s.vertex_c_x = COORD_W'(cx);
		s.vertex_c_y = COORD_W'(cy);
		s.pixel_x    = PIXEL_W'(px);
		s.pixel_y    = PIXEL_W'(py);
		return s;
	endfunction

	// Mostly well-formed: a triangle of random scale near the image with the
	// sample drawn from its pixel box, so about half land inside. A slice is
	// collinear, and some beats are pure noise to toggle every field bit.
	function automatic tpc_in_t make_sample(input int w, input int h);
		tpc_in_t      s;
		logic [127:0] noise;
		longint       vx[3];
		longint       vy[3];
		longint       ctr_x, ctr_y, span, lo_x, hi_x, lo_y, hi_y;
		int           k;
		int           i;
		if ($urandom_range(0, 99) < 15) begin
			noise = {$urandom, $urandom, $urandom, $urandom};
			s = noise[IN_BITS-1:0];
			return s;
		end
		case ($urandom_range(0, 3))
			0: span = 64;
			1: span = 512;
			2: span = 4096;
			default: span = 32768;
		endcase
		ctr_x = $urandom_range(0, w * 16);
		ctr_y = $urandom_range(0, h * 16);
		for (i = 0; i < 3; i++) begin
			vx[i] = clamp_coord(ctr_x + longint'($urandom_range(0, 2 * span)) - span);
			vy[i] = clamp_coord(ctr_y + longint'($urandom_range(0, 2 * span)) - span);
		end
		// collinear or repeated vertex
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, 2);
			vx[2] = clamp_coord(vx[0] + k * (vx[1] - vx[0]));
			vy[2] = clamp_coord(vy[0] + k * (vy[1] - vy[0]));
		end
		lo_x = vx[0];
		hi_x = vx[0];
		lo_y = vy[0];
		hi_y = vy[0];
		for (i = 1; i < 3; i++) begin
			lo_x = (vx[i] < lo_x) ? vx[i] : lo_x;
			hi_x = (vx[i] > hi_x) ? vx[i] : hi_x;
			lo_y = (vy[i] < lo_y) ? vy[i] : lo_y;
			hi_y = (vy[i] > hi_y) ? vy[i] : hi_y;
		end
		// whole pixels inside the vertex box, within the pixel field
		lo_x = (lo_x < 0) ? 0 : (lo_x + 15) / 16;
		lo_y = (lo_y < 0) ? 0 : (lo_y + 15) / 16;
		hi_x = (hi_x < 0) ? -1 : hi_x / 16;
		hi_y = (hi_y < 0) ? -1 : hi_y / 16;
		hi_x = (hi_x > 1023) ? 1023 : hi_x;
		hi_y = (hi_y > 1023) ? 1023 : hi_y;
		s.vertex_a_x = COORD_W'(vx[0]);
		s.vertex_a_y = COORD_W'(vy[0]);
		s.vertex_b_x = COORD_W'(vx[1]);
		s.vertex_b_y = COORD_W'(vy[1]);
		s.vertex_c_x = COORD_W'(vx[2]);
		s.vertex_c_y = COORD_W'(vy[2]);
		s.pixel_x = (lo_x <= hi_x && $urandom_range(0, 9) != 0) ?
			PIXEL_W'($urandom_range(int'(lo_x), int'(hi_x))) : PIXEL_W'($urandom_range(0, 1023));
		s.pixel_y = (lo_y <= hi_y && $urandom_range(0, 9) != 0) ?
			PIXEL_W'($urandom_range(int'(lo_y), int'(hi_y))) : PIXEL_W'($urandom_range(0, 1023));
		return s;
	endfunction

	// one sample beat; returns on the edge where it is taken
	task automatic send_sample(input tpc_in_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(s);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// both size registers, back to back; pipe must be empty
	task automatic set_image(input int w, input int h);
		cfg_wr_en   <= 1'b1;
		cfg_addr    <= REG_IMAGE_WIDTH;
		cfg_wr_data <= SIZE_W'(w);
		@(posedge clk);
		cfg_addr    <= REG_IMAGE_HEIGHT;
		cfg_wr_data <= SIZE_W'(h);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic run_phase(input int w, input int h, input int idle, input int stall,
			input int count);
		drain_results();
		set_image(w, h);
		send_idle_pct = idle;
		stall_pct     = stall;
		repeat (count)
			send_sample(make_sample(w, h));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset image size of 200 x 200
		// right triangle (1,1) (100,1) (1,100): interior, vertices, edges, outside
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 10, 10));
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 1, 1));
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 100, 1));
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 50, 1));
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 50, 51));
		send_sample(triangle_item(16, 16, 1600, 16, 16, 1600, 60, 60));
		// opposite winding
		send_sample(triangle_item(16, 16, 16, 1600, 1600, 16, 10, 10));
		send_sample(triangle_item(16, 16, 16, 1600, 1600, 16, 60, 60));
		// collinear, area at the degenerate limit, and just above it
		send_sample(triangle_item(0, 0, 800, 800, 1600, 1600, 10, 10));
		send_sample(triangle_item(0, 0, 2, 0, 0, 1, 0, 0));
		send_sample(triangle_item(0, 0, 0, 1, 2, 0, 0, 0));
		send_sample(triangle_item(0, 0, 3, 0, 0, 1, 0, 0));
		send_sample(triangle_item(0, 0, 0, 1, 3, 0, 0, 0));
		// triangle larger than the image: last column/row in, one past out
		send_sample(triangle_item(0, 0, 6400, 0, 0, 6400, 199, 5));
		send_sample(triangle_item(0, 0, 6400, 0, 0, 6400, 200, 5));
		send_sample(triangle_item(0, 0, 6400, 0, 0, 6400, 5, 200));
		// negative vertices clipped at the origin
		send_sample(triangle_item(-800, -800, 1600, -800, -800, 1600, 0, 0));
		// coordinate extremes
		send_sample(triangle_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
		send_sample(triangle_item(32767, 32767, -32768, 32767, 32767, -32768, 199, 199));
		send_sample(triangle_item(-32768, -32768, 32767, -32768, 32767, 32767, 150, 20));
		send_sample(triangle_item(0, 0, 32767, 0, 0, 32767, 1023, 1023));
		// all vertices left/above the image: box collapses onto the origin
		send_sample(triangle_item(-32768, -100, -50, -32768, -10, -10, 0, 0));
		// all vertices past the image
		send_sample(triangle_item(4000, 4000, 5000, 4000, 4000, 5000, 199, 199));

		// random phases; each one starts with the pipe drained
		run_phase(1024, 1024, 0, 0, 200);
		run_phase(1024, 1024, 0, 0, 150);
		run_phase(640, 480, 88, 0, 250);
		run_phase(1, 1, 0, 88, 60);
		run_phase(300, 1024, 0, 88, 200);
		run_phase(0, 2047, 36, 36, 60);
		run_phase(2047, 0, 36, 36, 60);
		run_phase(2047, 2047, 36, 36, 200);
		run_phase(200, 200, 36, 36, 250);

		drain_results();
		// let any stray beat surface
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tpc_pkg.sv
rtl/tpc_front.sv
rtl/tpc_edge.sv
rtl/tpc_divider.sv
rtl/tpc_out_buf.sv
rtl/triangle_pixel_coverage.sv
tb/coverage_checker.sv
tb/tb.sv
